// ===== sv/egcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, types and sequencer states for the extended gcd block.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int unsigned WIDTH = 64;
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Operands handed to the shared divide unit on start
  typedef struct packed {
    word_t dividend;
    word_t divisor;
    word_t multiplier;
  } div_op_t;

  // Results of the divide unit, valid while done is high
  typedef struct packed {
    logic  done;
    logic  busy;
    word_t quotient;
    word_t remainder;
    word_t product;
  } div_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_END,
    ST_FDIV,
    ST_FINISH
  } egcd_state_e;

endpackage

// ===== sv/egcd_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_req_if
// Request channel: the operand pair with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface egcd_req_if import egcd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t operand_a;
  word_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

// ===== sv/egcd_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_rsp_if
// Result channel: gcd and cofactor with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface egcd_rsp_if import egcd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t divisor;
  word_t cofactor;

  modport source (output valid, output divisor, output cofactor, input ready);
  modport sink   (input valid, input divisor, input cofactor, output ready);
endinterface

// ===== sv/egcd_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egcd_div
// Shared restoring divider, one quotient bit per cycle. Alongside it a
// Horner accumulator builds quotient * multiplier from the same bits.
// ----------------------------------------------------------------------------
module egcd_div import egcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  div_op_t op_i,
  output div_res_t res_o
);

  logic  busy_q, busy_d;
  logic  done_q, done_d;
  cnt_t  cnt_q, cnt_d;
  word_t dvd_q, dvd_d;
  word_t dsr_q, dsr_d;
  word_t mul_q, mul_d;
  word_t rem_q, rem_d;
  word_t acc_q, acc_d;

  logic [WIDTH:0] rem_sh;
  logic [WIDTH:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, dvd_q[WIDTH-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_q};
  assign ge      = ~rem_sub[WIDTH];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    mul_d  = mul_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = cnt_t'(WIDTH - 1);
      dvd_d  = op_i.dividend;
      dsr_d  = op_i.divisor;
      mul_d  = op_i.multiplier;
      rem_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift in where the dividend bits leave
      dvd_d = {dvd_q[WIDTH-2:0], ge};
      rem_d = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      acc_d = {acc_q[WIDTH-2:0], 1'b0} + (ge ? mul_q : '0);
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    mul_q <= mul_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
  end

  assign res_o.done      = done_q;
  assign res_o.busy      = busy_q;
  assign res_o.quotient  = dvd_q;
  assign res_o.remainder = rem_q;
  assign res_o.product   = acc_q;

  a_rem_below_dsr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (dsr_q != '0) |-> rem_q < dsr_q)
    else $error("remainder not below divisor");

  a_last_bit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (cnt_q == '0) && !start_i |=> !busy_q && done_q)
    else $error("divider did not finish after last bit");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q || $past(start_i))
    else $error("done raised while divider still busy");

endmodule

// ===== sv/extended_gcd_modular_inverse.sv =====
`timescale 1ns / 1ps
// Zero modulus or equal operands skip the Euclid loop and go straight to ST_FINISH.
// General case: n Euclid steps, each one division on the shared unit,
//   n up to 93 at WIDTH = 64; a final b / gcd division may follow.
// Throughput: one request at a time; the shared bit-serial divider sets the rate.
// Reset: asynchronous, active low; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// extended_gcd_modular_inverse
// Extended Euclid on one shared divide/multiply-accumulate unit: gives the
// gcd of the operands and the cofactor x with x * a = gcd mod b.
// ----------------------------------------------------------------------------
module extended_gcd_modular_inverse import egcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  egcd_req_if.sink   req_i,
  egcd_rsp_if.source rsp_o
);

  egcd_state_e state_q, state_d;
  word_t       rp_q, rp_d;
  word_t       rc_q, rc_d;
  word_t       up_q, up_d;
  word_t       uc_q, uc_d;
  word_t       b_q, b_d;
  logic        par_q, par_d;

  logic        out_valid_q, out_valid_d;
  word_t       out_div_q, out_cof_q;
  logic        load;

  logic        div_start;
  div_op_t     div_op;
  div_res_t    div_res;

  egcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .op_i    (div_op),
    .res_o   (div_res)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign load        = (state_q == ST_FINISH) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    rp_d      = rp_q;
    rc_d      = rc_q;
    up_d      = up_q;
    uc_d      = uc_q;
    b_d       = b_q;
    par_d     = par_q;
    div_start = 1'b0;
    div_op.dividend   = rp_q;
    div_op.divisor    = rc_q;
    div_op.multiplier = uc_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          b_d   = req_i.operand_b;
          rp_d  = req_i.operand_b;
          rc_d  = req_i.operand_a;
          up_d  = '0;
          uc_d  = word_t'(1);
          par_d = 1'b0;
          if (req_i.operand_b == '0) begin
            rp_d    = req_i.operand_a;
            up_d    = word_t'(1);
            state_d = ST_FINISH;
          end else if (req_i.operand_a == req_i.operand_b) begin
            rp_d    = req_i.operand_a;
            state_d = ST_FINISH;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (rc_q == '0) begin
          state_d = ST_END;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          // advance the remainder and cofactor pairs
          rp_d    = rc_q;
          rc_d    = div_res.remainder;
          up_d    = uc_q;
          uc_d    = up_q + div_res.product;
          par_d   = ~par_q;
          state_d = ST_CHECK;
        end
      end
      ST_END: begin
        if (!par_q && (up_q != '0)) begin
          div_op.dividend   = b_q;
          div_op.divisor    = rp_q;
          div_op.multiplier = '0;
          div_start         = 1'b1;
          state_d           = ST_FDIV;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FDIV: begin
        if (div_res.done) begin
          up_d    = div_res.quotient - up_q;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q <= rp_d;
    rc_q <= rc_d;
    up_q <= up_d;
    uc_q <= uc_d;
    b_q  <= b_d;
    if (load) begin
      out_div_q <= rp_q;
      out_cof_q <= up_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.divisor  = out_div_q;
  assign rsp_o.cofactor = out_cof_q;

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_res.busy)
    else $error("divider started while busy");

  a_div_state_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_FDIV) |-> div_res.busy || div_res.done)
    else $error("waiting on an idle divider");

  a_zero_gcd_cofactor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_div_q == '0) |-> out_cof_q == word_t'(1))
    else $error("zero gcd must come with cofactor one");

endmodule
